/* rtl/core/sccb_pkg.sv */
// sccb_pkg: shared types and constants for the SCCB register master.
// Holds sequencer step codes, command codes, CSR indexes and reset values.
// No dependencies.
package sccb_pkg;

   // Default width of the phase/gap timer
   localparam int TIMER_BITS_DEFAULT = 16;

   // Register reset values
   localparam logic [7:0]  DEVICE_ID_RESET = 8'h42;
   localparam logic [15:0] PHASE_RESET     = 16'd500;
   localparam logic [15:0] GAP_RESET       = 16'd100;
   localparam logic [7:0]  READ_BIT        = 8'h01;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEVICE_ID = 2'd0;
   localparam logic [1:0] CSR_PHASE     = 2'd1;
   localparam logic [1:0] CSR_GAP       = 2'd2;

   // Command codes carried with each item
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Byte selector codes
   localparam logic [1:0] SEL_ID   = 2'd0;
   localparam logic [1:0] SEL_REG  = 2'd1;
   localparam logic [1:0] SEL_LAST = 2'd2;

   // Bus sequencer steps
   typedef enum logic [4:0] {
      ST_IDLE  = 5'd0,
      ST_ST_A  = 5'd1,
      ST_ST_B  = 5'd2,
      ST_ST_C  = 5'd3,
      ST_ST_D  = 5'd4,
      ST_WB_LO = 5'd5,
      ST_WB_HI = 5'd6,
      ST_WA_LO = 5'd7,
      ST_WA_HI = 5'd8,
      ST_GAP   = 5'd9,
      ST_SP_A  = 5'd10,
      ST_SP_B  = 5'd11,
      ST_SP_C  = 5'd12,
      ST_GAP2  = 5'd13,
      ST_RB_LO = 5'd14,
      ST_RB_HI = 5'd15,
      ST_NK_A  = 5'd16,
      ST_NK_B  = 5'd17,
      ST_NK_C  = 5'd18,
      ST_NK_D  = 5'd19
   } step_type;

   // Driven pin levels
   typedef struct packed {
      logic scl;
      logic sda_level;
      logic sda_drive;
   } pins_type;

endpackage

/* rtl/core/sccb_register_master.sv */
// sccb_register_master: pin-level SCCB register write/read sequencer.
// Single module; depends on sccb_pkg for step codes, commands and constants.
//
// Each request transaction is one timer tick that carries the sampled SDA level and
// optionally a write (cmd 1) or read (cmd 2) command, taken only while idle. Every
// request produces exactly one response transaction holding the driven SCL/SDA
// levels, busy, a one-item done pulse, the ack-error flag and the last byte read.
// One request is accepted per clock cycle unless a response waits with rsp_tready low;
// each response is registered in the output register, and a request is still taken while
// it is drained in the same cycle. The sequencer and timer update in one registered step
// per item. Phase and gap lengths come from the CSRs (phase 0 counts as 1, gap 0 is
// skipped, both saturate at 2^TIMER_BITS-1); CSR writes are taken every cycle and take
// effect at once, also in the middle of a transaction; device_id is sampled as each
// byte starts.
module sccb_register_master #(
   parameter int TIMER_BITS = sccb_pkg::TIMER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] reg_addr, [15:8] wr_data, [16] sda_in, zero pad
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] scl, [1] sda_level, [2] sda_drive, [3] busy_res,
                                    // [4] done_res, [5] ack_error, [13:6] read_data, zero pad
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int LEN_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [LEN_W-1:0] TIMER_MAX = LEN_W'({TIMER_BITS{1'b1}});

   // Sequencer state that one advance step may change
   typedef struct packed {
      sccb_pkg::step_type    step;
      logic [3:0]            bit_index;
      logic [7:0]            shift_byte;
      logic [TIMER_BITS-1:0] phase_count;
      logic                  fail;
      logic [1:0]            byte_sel;
      logic [7:0]            last_read;
      logic                  done;
   } seq_state_type;

   // Configuration registers
   logic [7:0]  device_id_ff;
   logic [15:0] phase_ticks_ff, gap_ticks_ff;

   // Sequencer registers
   sccb_pkg::step_type    step_ff;
   logic [3:0]            bit_index_ff;
   logic [7:0]            shift_byte_ff;
   logic [TIMER_BITS-1:0] phase_count_ff;
   logic                  fail_ff;
   logic [1:0]            byte_sel_ff;
   logic [7:0]            last_read_ff;
   logic                  read_mode_ff, read_mode_in;
   logic [7:0]            held_reg_ff, held_reg_in;
   logic [7:0]            held_data_ff, held_data_in;

   // Output register
   logic        rsp_tvalid_ff;
   logic [15:0] rsp_tdata_ff;
   logic [15:0] rsp_tdata_in;

   seq_state_type cur_st, nxt_st;
   sccb_pkg::pins_type pins;
   logic req_accept;
   logic [1:0] cmd;
   logic sda_in;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign cmd        = req_tuser;
   assign sda_in     = req_tdata[16];

   // Length of a step in ticks, saturated to the timer range
   function automatic logic [TIMER_BITS-1:0] step_len(sccb_pkg::step_type s,
                                                      logic [15:0] phase, logic [15:0] gap);
      logic [15:0]      d;
      logic [LEN_W-1:0] dext;
      if (s == sccb_pkg::ST_GAP || s == sccb_pkg::ST_GAP2) begin
         d = gap;
      end else begin
         d = (phase == 16'd0) ? 16'd1 : phase;
      end
      dext = LEN_W'(d);
      return (dext > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0] : dext[TIMER_BITS-1:0];
   endfunction

   // Load the next byte to send and start its first bit
   function automatic seq_state_type load_byte(seq_state_type s, logic [7:0] dev,
                                               logic rmode, logic [7:0] hreg,
                                               logic [7:0] hdata);
      seq_state_type r;
      r = s;
      if (s.byte_sel == sccb_pkg::SEL_ID) begin
         r.shift_byte = dev;
      end else if (s.byte_sel == sccb_pkg::SEL_REG) begin
         r.shift_byte = hreg;
      end else if (rmode) begin
         r.shift_byte = dev | sccb_pkg::READ_BIT;
      end else begin
         r.shift_byte = hdata;
      end
      r.bit_index   = 4'd0;
      r.step        = sccb_pkg::ST_WB_LO;
      r.phase_count = TIMER_BITS'(1);
      return r;
   endfunction

   // End the current step and enter the next one
   function automatic seq_state_type advance(seq_state_type s, logic sda, logic [7:0] dev,
                                             logic rmode, logic [7:0] hreg,
                                             logic [7:0] hdata);
      seq_state_type r;
      logic [3:0]    bi;
      logic [7:0]    sh;
      r = s;
      r.done = 1'b0;
      r.phase_count = TIMER_BITS'(1);
      bi = s.bit_index + 4'd1;
      sh = {s.shift_byte[6:0], sda};
      unique case (s.step)
         sccb_pkg::ST_ST_A:  r.step = sccb_pkg::ST_ST_B;
         sccb_pkg::ST_ST_B:  r.step = sccb_pkg::ST_ST_C;
         sccb_pkg::ST_ST_C:  r.step = sccb_pkg::ST_ST_D;
         sccb_pkg::ST_ST_D:  r = load_byte(s, dev, rmode, hreg, hdata);
         sccb_pkg::ST_WB_LO: r.step = sccb_pkg::ST_WB_HI;
         sccb_pkg::ST_WB_HI: begin
            r.bit_index = bi;
            r.step = (bi >= 4'd8) ? sccb_pkg::ST_WA_LO : sccb_pkg::ST_WB_LO;
         end
         sccb_pkg::ST_WA_LO: r.step = sccb_pkg::ST_WA_HI;
         sccb_pkg::ST_WA_HI: begin
            if (sda) r.fail = 1'b1;
            if (s.byte_sel == sccb_pkg::SEL_ID) begin
               r.step = sccb_pkg::ST_GAP;
            end else if (s.byte_sel == sccb_pkg::SEL_REG) begin
               r.step = rmode ? sccb_pkg::ST_SP_A : sccb_pkg::ST_GAP;
            end else if (rmode) begin
               r.bit_index  = 4'd0;
               r.shift_byte = 8'd0;
               r.step       = sccb_pkg::ST_RB_LO;
            end else begin
               r.step = sccb_pkg::ST_SP_A;
            end
         end
         sccb_pkg::ST_GAP: begin
            r.byte_sel = s.byte_sel + 2'd1;
            r = load_byte(r, dev, rmode, hreg, hdata);
         end
         sccb_pkg::ST_SP_A:  r.step = sccb_pkg::ST_SP_B;
         sccb_pkg::ST_SP_B:  r.step = sccb_pkg::ST_SP_C;
         sccb_pkg::ST_SP_C: begin
            if (rmode && s.byte_sel == sccb_pkg::SEL_REG) begin
               r.step = sccb_pkg::ST_GAP2;
            end else begin
               r.step        = sccb_pkg::ST_IDLE;
               r.phase_count = '0;
               r.done        = 1'b1;
            end
         end
         sccb_pkg::ST_GAP2: begin
            r.byte_sel = sccb_pkg::SEL_LAST;
            r.step     = sccb_pkg::ST_ST_A;
         end
         sccb_pkg::ST_RB_LO: r.step = sccb_pkg::ST_RB_HI;
         sccb_pkg::ST_RB_HI: begin
            r.shift_byte = sh;
            r.bit_index  = bi;
            if (bi >= 4'd8) begin
               r.last_read = sh;
               r.step      = sccb_pkg::ST_NK_A;
            end else begin
               r.step = sccb_pkg::ST_RB_LO;
            end
         end
         sccb_pkg::ST_NK_A:  r.step = sccb_pkg::ST_NK_B;
         sccb_pkg::ST_NK_B:  r.step = sccb_pkg::ST_NK_C;
         sccb_pkg::ST_NK_C:  r.step = sccb_pkg::ST_NK_D;
         sccb_pkg::ST_NK_D:  r.step = sccb_pkg::ST_SP_A;
         default: begin
            r.step        = sccb_pkg::ST_IDLE;
            r.phase_count = '0;
         end
      endcase
      return r;
   endfunction

   // Current sequencer state
   always_comb begin
      cur_st.step        = step_ff;
      cur_st.bit_index   = bit_index_ff;
      cur_st.shift_byte  = shift_byte_ff;
      cur_st.phase_count = phase_count_ff;
      cur_st.fail        = fail_ff;
      cur_st.byte_sel    = byte_sel_ff;
      cur_st.last_read   = last_read_ff;
      cur_st.done        = 1'b0;
   end

   // Next state: start a command when idle, else count or advance;
   // a zero-length gap is passed in the same tick
   always_comb begin
      nxt_st       = cur_st;
      read_mode_in = read_mode_ff;
      held_reg_in  = held_reg_ff;
      held_data_in = held_data_ff;
      if (step_ff == sccb_pkg::ST_IDLE) begin
         if (cmd == sccb_pkg::CMD_WRITE || cmd == sccb_pkg::CMD_READ) begin
            read_mode_in       = (cmd == sccb_pkg::CMD_READ);
            held_reg_in        = req_tdata[7:0];
            held_data_in       = req_tdata[15:8];
            nxt_st.fail        = 1'b0;
            nxt_st.byte_sel    = sccb_pkg::SEL_ID;
            nxt_st.bit_index   = 4'd0;
            nxt_st.step        = sccb_pkg::ST_ST_A;
            nxt_st.phase_count = TIMER_BITS'(1);
         end
      end else begin
         if (phase_count_ff >= step_len(step_ff, phase_ticks_ff, gap_ticks_ff)) begin
            nxt_st = advance(cur_st, sda_in, device_id_ff, read_mode_ff,
                             held_reg_ff, held_data_ff);
         end else begin
            nxt_st.phase_count = phase_count_ff + 1'b1;
         end
         if (!nxt_st.done && gap_ticks_ff == 16'd0 &&
             (nxt_st.step == sccb_pkg::ST_GAP || nxt_st.step == sccb_pkg::ST_GAP2)) begin
            nxt_st = advance(nxt_st, sda_in, device_id_ff, read_mode_ff,
                             held_reg_ff, held_data_ff);
         end
      end
   end

   // Pin levels for the step just entered
   always_comb begin
      logic bit_val;
      bit_val = nxt_st.shift_byte[3'd7 - nxt_st.bit_index[2:0]];
      pins = '{scl: 1'b1, sda_level: 1'b1, sda_drive: 1'b1};
      unique case (nxt_st.step)
         sccb_pkg::ST_ST_C:  pins.sda_level = 1'b0;
         sccb_pkg::ST_ST_D:  pins = '{scl: 1'b0, sda_level: 1'b0, sda_drive: 1'b1};
         sccb_pkg::ST_WB_LO: pins = '{scl: 1'b0, sda_level: bit_val, sda_drive: 1'b1};
         sccb_pkg::ST_WB_HI: pins.sda_level = bit_val;
         sccb_pkg::ST_WA_LO,
         sccb_pkg::ST_RB_LO: pins = '{scl: 1'b0, sda_level: 1'b0, sda_drive: 1'b0};
         sccb_pkg::ST_WA_HI,
         sccb_pkg::ST_RB_HI: pins = '{scl: 1'b1, sda_level: 1'b0, sda_drive: 1'b0};
         sccb_pkg::ST_GAP:
            pins = '{scl: 1'b0, sda_level: nxt_st.shift_byte[0], sda_drive: 1'b1};
         sccb_pkg::ST_SP_A,
         sccb_pkg::ST_NK_D:  pins = '{scl: 1'b0, sda_level: 1'b0, sda_drive: 1'b1};
         sccb_pkg::ST_SP_B:  pins.sda_level = 1'b0;
         sccb_pkg::ST_NK_A,
         sccb_pkg::ST_NK_C:  pins.scl = 1'b0;
         default: ;
      endcase
   end

   // Response word
   always_comb begin
      rsp_tdata_in = {2'b00, nxt_st.last_read, nxt_st.fail, nxt_st.done,
                      nxt_st.step != sccb_pkg::ST_IDLE,
                      pins.sda_drive, pins.sda_level, pins.scl};
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff   <= sccb_pkg::DEVICE_ID_RESET;
         phase_ticks_ff <= sccb_pkg::PHASE_RESET;
         gap_ticks_ff   <= sccb_pkg::GAP_RESET;
      end else if (csr_valid) begin
         if (csr_index == sccb_pkg::CSR_DEVICE_ID) device_id_ff <= csr_data[7:0];
         if (csr_index == sccb_pkg::CSR_PHASE) phase_ticks_ff <= csr_data;
         if (csr_index == sccb_pkg::CSR_GAP) gap_ticks_ff <= csr_data;
      end
   end

   // Sequencer registers, updated once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= sccb_pkg::ST_IDLE;
         bit_index_ff   <= '0;
         shift_byte_ff  <= '0;
         phase_count_ff <= '0;
         fail_ff        <= 1'b0;
         byte_sel_ff    <= sccb_pkg::SEL_ID;
         last_read_ff   <= '0;
         read_mode_ff   <= 1'b0;
         held_reg_ff    <= '0;
         held_data_ff   <= '0;
      end else if (req_accept) begin
         step_ff        <= nxt_st.step;
         bit_index_ff   <= nxt_st.bit_index;
         shift_byte_ff  <= nxt_st.shift_byte;
         phase_count_ff <= nxt_st.phase_count;
         fail_ff        <= nxt_st.fail;
         byte_sel_ff    <= nxt_st.byte_sel;
         last_read_ff   <= nxt_st.last_read;
         read_mode_ff   <= read_mode_in;
         held_reg_ff    <= held_reg_in;
         held_data_ff   <= held_data_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_tdata_ff <= rsp_tdata_in;
   end

`ifndef SYNTHESIS
   // A done pulse always reports the block as idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[4] |-> !rsp_tdata_ff[3])
      else $error("done reported while busy");

   // SDA level is low whenever the line is released
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tdata_ff[2] |-> !rsp_tdata_ff[1])
      else $error("sda level high while released");

   // A command taken while idle starts the start condition
   assert property (@(posedge clock) disable iff (reset)
      req_accept && step_ff == sccb_pkg::ST_IDLE &&
      (cmd == sccb_pkg::CMD_WRITE || cmd == sccb_pkg::CMD_READ)
      |=> step_ff == sccb_pkg::ST_ST_A && phase_count_ff == TIMER_BITS'(1))
      else $error("command did not start sequence");

   // The phase timer never sits at zero while a transaction runs
   assert property (@(posedge clock) disable iff (reset)
      step_ff != sccb_pkg::ST_IDLE |-> phase_count_ff != '0)
      else $error("phase timer zero while busy");
`endif

endmodule

/* test/tb.sv */
// tb: self-checking testbench for sccb_register_master (SCCB register write/read master).
// Holds its own tick-level model of the bus sequencer and checks every response field.
// Depends on sccb_pkg and sccb_register_master only.
module tb;

   // Unused command code, must be ignored by the block
   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;

   // Pin levels and status expected for one tick
   typedef struct packed {
      logic       scl;
      logic       sda_level;
      logic       sda_drive;
      logic       busy;
      logic       done;
      logic       ack_error;
      logic [7:0] read_data;
   } tick_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = sccb_pkg::CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = sccb_pkg::CSR_DEVICE_ID;
   logic [15:0] csr_data = '0;

   // Expected tick status, oldest first
   tick_status_type expected_status[$];
   int errors = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_req = 1'b0;

   // Bus sequencer mirror
   sccb_pkg::step_type bus_step;
   logic [3:0] bit_cnt;
   logic [7:0] shreg;
   logic [15:0] phase_cnt;
   logic       ack_fail;
   logic       rd_mode;
   logic [7:0] reg_hold;
   logic [7:0] data_hold;
   logic [7:0] rd_byte;
   logic [1:0] byte_pick;
   logic [7:0] cfg_id;
   logic [15:0] cfg_phase;
   logic [15:0] cfg_gap;

   sccb_register_master DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Bus sequencer model
   // ---------------------------------------------------------------

   // Length of a step in ticks; gaps may be zero, phases never
   function automatic logic [15:0] span_of(sccb_pkg::step_type s);
      if (s == sccb_pkg::ST_GAP || s == sccb_pkg::ST_GAP2) return cfg_gap;
      return (cfg_phase == 16'd0) ? 16'd1 : cfg_phase;
   endfunction

   function automatic void enter_step(sccb_pkg::step_type s);
      bus_step = s;
      phase_cnt = 16'd1;
   endfunction

   // Pick the next byte to shift out; id is taken fresh each time
   function automatic void load_next_byte();
      if (byte_pick == sccb_pkg::SEL_ID) shreg = cfg_id;
      else if (byte_pick == sccb_pkg::SEL_REG) shreg = reg_hold;
      else if (rd_mode) shreg = cfg_id | sccb_pkg::READ_BIT;
      else shreg = data_hold;
      bit_cnt = 4'd0;
      enter_step(sccb_pkg::ST_WB_LO);
   endfunction

   // Close the current step; returns 1 when the transaction ends
   function automatic logic end_step(logic sda);
      logic finished;
      finished = 1'b0;
      case (bus_step)
         sccb_pkg::ST_ST_A: enter_step(sccb_pkg::ST_ST_B);
         sccb_pkg::ST_ST_B: enter_step(sccb_pkg::ST_ST_C);
         sccb_pkg::ST_ST_C: enter_step(sccb_pkg::ST_ST_D);
         sccb_pkg::ST_ST_D: load_next_byte();
         sccb_pkg::ST_WB_LO: enter_step(sccb_pkg::ST_WB_HI);
         sccb_pkg::ST_WB_HI: begin
            bit_cnt = bit_cnt + 4'd1;
            enter_step((bit_cnt >= 4'd8) ? sccb_pkg::ST_WA_LO : sccb_pkg::ST_WB_LO);
         end
         sccb_pkg::ST_WA_LO: enter_step(sccb_pkg::ST_WA_HI);
         sccb_pkg::ST_WA_HI: begin
            if (sda) ack_fail = 1'b1;
            if (byte_pick == sccb_pkg::SEL_ID) enter_step(sccb_pkg::ST_GAP);
            else if (byte_pick == sccb_pkg::SEL_REG)
               enter_step(rd_mode ? sccb_pkg::ST_SP_A : sccb_pkg::ST_GAP);
            else if (rd_mode) begin
               bit_cnt = 4'd0;
               shreg = 8'd0;
               enter_step(sccb_pkg::ST_RB_LO);
            end else enter_step(sccb_pkg::ST_SP_A);
         end
         sccb_pkg::ST_GAP: begin
            byte_pick = byte_pick + 2'd1;
            load_next_byte();
         end
         sccb_pkg::ST_SP_A: enter_step(sccb_pkg::ST_SP_B);
         sccb_pkg::ST_SP_B: enter_step(sccb_pkg::ST_SP_C);
         sccb_pkg::ST_SP_C: begin
            // first half of a read continues after the mid gap
            if (rd_mode && byte_pick == sccb_pkg::SEL_REG) enter_step(sccb_pkg::ST_GAP2);
            else begin
               bus_step = sccb_pkg::ST_IDLE;
               phase_cnt = 16'd0;
               finished = 1'b1;
            end
         end
         sccb_pkg::ST_GAP2: begin
            byte_pick = sccb_pkg::SEL_LAST;
            enter_step(sccb_pkg::ST_ST_A);
         end
         sccb_pkg::ST_RB_LO: enter_step(sccb_pkg::ST_RB_HI);
         sccb_pkg::ST_RB_HI: begin
            shreg = {shreg[6:0], sda};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
               rd_byte = shreg;
               enter_step(sccb_pkg::ST_NK_A);
            end else enter_step(sccb_pkg::ST_RB_LO);
         end
         sccb_pkg::ST_NK_A: enter_step(sccb_pkg::ST_NK_B);
         sccb_pkg::ST_NK_B: enter_step(sccb_pkg::ST_NK_C);
         sccb_pkg::ST_NK_C: enter_step(sccb_pkg::ST_NK_D);
         sccb_pkg::ST_NK_D: enter_step(sccb_pkg::ST_SP_A);
         default: begin
            bus_step = sccb_pkg::ST_IDLE;
            phase_cnt = 16'd0;
         end
      endcase
      return finished;
   endfunction

   // Advance the model by one accepted tick and queue the expected status
   function automatic void predict_tick(logic [1:0] cmd, logic [7:0] reg_a,
                                        logic [7:0] data, logic sda);
      logic finished;
      logic bitv;
      tick_status_type st;
      finished = 1'b0;
      if (bus_step == sccb_pkg::ST_IDLE) begin
         if (cmd == sccb_pkg::CMD_WRITE || cmd == sccb_pkg::CMD_READ) begin
            rd_mode = (cmd == sccb_pkg::CMD_READ);
            reg_hold = reg_a;
            data_hold = data;
            ack_fail = 1'b0;
            byte_pick = sccb_pkg::SEL_ID;
            bit_cnt = 4'd0;
            enter_step(sccb_pkg::ST_ST_A);
         end
      end else begin
         if (phase_cnt >= span_of(bus_step)) finished = end_step(sda);
         else phase_cnt = phase_cnt + 16'd1;
         // zero-length gaps take no tick
         while (!finished && bus_step != sccb_pkg::ST_IDLE && span_of(bus_step) == 16'd0)
            finished = end_step(sda);
      end

      bitv = shreg[3'd7 - bit_cnt[2:0]];
      st.scl = 1'b1;
      st.sda_level = 1'b1;
      st.sda_drive = 1'b1;
      case (bus_step)
         sccb_pkg::ST_ST_C: st.sda_level = 1'b0;
         sccb_pkg::ST_ST_D: begin
            st.scl = 1'b0;
            st.sda_level = 1'b0;
         end
         sccb_pkg::ST_WB_LO: begin
            st.scl = 1'b0;
            st.sda_level = bitv;
         end
         sccb_pkg::ST_WB_HI: st.sda_level = bitv;
         sccb_pkg::ST_WA_LO, sccb_pkg::ST_RB_LO: begin
            st.scl = 1'b0;
            st.sda_level = 1'b0;
            st.sda_drive = 1'b0;
         end
         sccb_pkg::ST_WA_HI, sccb_pkg::ST_RB_HI: begin
            st.sda_level = 1'b0;
            st.sda_drive = 1'b0;
         end
         sccb_pkg::ST_GAP: begin
            st.scl = 1'b0;
            st.sda_level = shreg[0];
         end
         sccb_pkg::ST_SP_A, sccb_pkg::ST_NK_D: begin
            st.scl = 1'b0;
            st.sda_level = 1'b0;
         end
         sccb_pkg::ST_SP_B: st.sda_level = 1'b0;
         sccb_pkg::ST_NK_A, sccb_pkg::ST_NK_C: st.scl = 1'b0;
         default: ;
      endcase
      st.busy = (bus_step != sccb_pkg::ST_IDLE);
      st.done = finished;
      st.ack_error = ack_fail;
      st.read_data = rd_byte;
      expected_status.push_back(st);
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------

   // One request transaction, then an optional random sender gap
   task automatic send_item(logic [1:0] cmd, logic [7:0] reg_a, logic [7:0] data, logic sda);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, sda, data, reg_a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tick(cmd, reg_a, data, sda);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   // Register write; only once all responses are in
   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         sccb_pkg::CSR_DEVICE_ID: cfg_id = value[7:0];
         sccb_pkg::CSR_PHASE: cfg_phase = value;
         sccb_pkg::CSR_GAP: cfg_gap = value;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] id, logic [15:0] phase, logic [15:0] gap);
      write_csr(sccb_pkg::CSR_DEVICE_ID, {8'd0, id});
      write_csr(sccb_pkg::CSR_PHASE, phase);
      write_csr(sccb_pkg::CSR_GAP, gap);
   endtask

   // Tick until the sequencer is back to idle
   task automatic drain_bus();
      while (bus_step != sccb_pkg::ST_IDLE)
         send_item(sccb_pkg::CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
   endtask

   // Tick a running transfer to its end with a fixed ack level and read pattern
   task automatic finish_transfer(logic ack_lvl, logic [7:0] rd_pattern, logic noisy);
      logic [1:0] op;
      logic sda;
      while (bus_step != sccb_pkg::ST_IDLE) begin
         if (bus_step == sccb_pkg::ST_WA_HI) sda = ack_lvl;
         else if (bus_step == sccb_pkg::ST_RB_HI) sda = rd_pattern[3'd7 - bit_cnt[2:0]];
         else sda = 1'($urandom_range(1));
         // commands while busy must be ignored
         op = noisy ? 2'($urandom_range(3)) : sccb_pkg::CMD_TICK;
         send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)), sda);
      end
   endtask

   // One full transfer with a fixed ack level and read pattern on SDA
   task automatic run_transfer(logic [1:0] cmd, logic [7:0] reg_a, logic [7:0] data,
                               logic ack_lvl, logic [7:0] rd_pattern, logic noisy);
      send_item(cmd, reg_a, data, 1'($urandom_range(1)));
      finish_transfer(ack_lvl, rd_pattern, noisy);
   endtask

   // Mostly complete transfers with random content, a little noise
   task automatic run_random_round(int n_items);
      logic [1:0] op;
      logic sda;
      for (int i = 0; i < n_items; i++) begin
         if (bus_step == sccb_pkg::ST_IDLE) begin
            if ($urandom_range(9) < 8)
               op = $urandom_range(1) ? sccb_pkg::CMD_WRITE : sccb_pkg::CMD_READ;
            else op = $urandom_range(1) ? CMD_RESERVED : sccb_pkg::CMD_TICK;
         end else begin
            op = ($urandom_range(24) == 0) ? 2'($urandom_range(3)) : sccb_pkg::CMD_TICK;
         end
         // acks mostly low so that clean transfers dominate
         if (bus_step == sccb_pkg::ST_WA_HI) sda = ($urandom_range(3) == 0);
         else sda = 1'($urandom_range(1));
         send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)), sda);
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // One write under the reset values; the phase is shortened once the long
   // start phase has been seen to hold
   task automatic test_reset_config();
      send_item(sccb_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0);
      send_item(sccb_pkg::CMD_WRITE, 8'h5A, 8'hA5, 1'b0);
      repeat (40) send_item(sccb_pkg::CMD_TICK, 8'h00, 8'h00, 1'b1);
      write_csr(sccb_pkg::CSR_PHASE, 16'd1);
      finish_transfer(1'b0, 8'h00, 1'b0);
   endtask

   // Field extremes, ack errors, read patterns, ignored commands
   task automatic test_directed();
      set_config(8'hFF, 16'd1, 16'd0);
      send_item(CMD_RESERVED, 8'hFF, 8'hFF, 1'b1);
      send_item(sccb_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0);
      run_transfer(sccb_pkg::CMD_WRITE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
      run_transfer(sccb_pkg::CMD_WRITE, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0);
      run_transfer(sccb_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0);
      run_transfer(sccb_pkg::CMD_READ, 8'hFF, 8'h5A, 1'b1, 8'h00, 1'b1);
      run_transfer(sccb_pkg::CMD_WRITE, 8'hA5, 8'h5A, 1'b0, 8'h00, 1'b1);
      // zero phase length counts as one tick
      set_config(8'h00, 16'd0, 16'd1);
      run_transfer(sccb_pkg::CMD_READ, 8'h81, 8'h00, 1'b0, 8'hA5, 1'b0);
      run_transfer(sccb_pkg::CMD_WRITE, 8'h3C, 8'hC3, 1'b1, 8'h00, 1'b1);
   endtask

   // Largest register values, then shortened in the middle of a read
   task automatic test_long_timing();
      set_config(8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(CMD_RESERVED, 8'h00, 8'hFF, 1'b0);
      send_item(sccb_pkg::CMD_TICK, 8'hFF, 8'h00, 1'b1);
      send_item(sccb_pkg::CMD_READ, 8'h96, 8'h69, 1'b0);
      repeat (20) send_item(sccb_pkg::CMD_TICK, 8'hFF, 8'h00, 1'b1);
      set_config(8'h42, 16'd1, 16'd2);
      finish_transfer(1'b0, 8'h96, 1'b0);
   endtask

   // Random traffic under each idling profile, one round with a long receiver hold
   task automatic test_random_traffic();
      int send_mix[4] = '{0, 47, 0, 27};
      int stall_mix[4] = '{0, 0, 47, 27};
      logic [15:0] phase;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_mix[p];
         rsp_stall_pct = stall_mix[p];
         for (int r = 0; r < 2; r++) begin
            phase = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(2, 1));
            set_config(8'($urandom_range(255)), phase, 16'($urandom_range(3)));
            if (p == 0 && r == 1) hold_req = 1'b1;
            run_random_round(60);
         end
      end
      drain_bus();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      bus_step = sccb_pkg::ST_IDLE;
      bit_cnt = 4'd0;
      shreg = 8'd0;
      phase_cnt = 16'd0;
      ack_fail = 1'b0;
      rd_mode = 1'b0;
      reg_hold = 8'd0;
      data_hold = 8'd0;
      rd_byte = 8'd0;
      byte_pick = sccb_pkg::SEL_ID;
      cfg_id = sccb_pkg::DEVICE_ID_RESET;
      cfg_phase = sccb_pkg::PHASE_RESET;
      cfg_gap = sccb_pkg::GAP_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_directed();
      test_long_timing();
      test_random_traffic();

      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Response ready: random stalls, plus a long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void flag_mismatch(string field, int unsigned want_v, int unsigned got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
   endfunction

   // Response checker
   initial begin
      tick_status_type want;
      tick_status_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.scl = rsp_tdata[0];
            got.sda_level = rsp_tdata[1];
            got.sda_drive = rsp_tdata[2];
            got.busy = rsp_tdata[3];
            got.done = rsp_tdata[4];
            got.ack_error = rsp_tdata[5];
            got.read_data = rsp_tdata[13:6];
            if (expected_status.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, got %h", $time, rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               if (got.scl !== want.scl) flag_mismatch("scl", want.scl, got.scl);
               if (got.sda_level !== want.sda_level)
                  flag_mismatch("sda_level", want.sda_level, got.sda_level);
               if (got.sda_drive !== want.sda_drive)
                  flag_mismatch("sda_drive", want.sda_drive, got.sda_drive);
               if (got.busy !== want.busy) flag_mismatch("busy_res", want.busy, got.busy);
               if (got.done !== want.done) flag_mismatch("done_res", want.done, got.done);
               if (got.ack_error !== want.ack_error)
                  flag_mismatch("ack_error", want.ack_error, got.ack_error);
               if (got.read_data !== want.read_data)
                  flag_mismatch("read_data", want.read_data, got.read_data);
            end
         end
      end
   end

   // Watchdog: too many cycles without any transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule
